/* rtl/y2r_pkg.sv */
// Shared types, constants and arithmetic helpers for the YUYV to RGB pair converter.
package y2r_pkg;

	localparam int COEF_W  = 12;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 3;
	localparam int PROD_W  = 22;
	localparam int ACC_W   = 24;
	localparam int SAT_W   = 18;
	localparam int RECIP_W = 19;
	localparam int DIV_SHIFT = 28;

	localparam logic [COEF_W-1:0] LUMA_GAIN_RST    = 12'd1164;
	localparam logic [COEF_W-1:0] RED_FROM_V_RST   = 12'd1159;
	localparam logic [COEF_W-1:0] GREEN_FROM_U_RST = 12'd380;
	localparam logic [COEF_W-1:0] GREEN_FROM_V_RST = 12'd813;
	localparam logic [COEF_W-1:0] BLUE_FROM_U_RST  = 12'd2018;

	localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
	localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;

	// Largest sum that still divides to 255 (255 * 1000 + 999).
	localparam logic [SAT_W-1:0]        SAT_MAX   = 18'd255999;
	localparam logic signed [ACC_W-1:0] SAT_LIMIT = 24'sd256000;

	// ceil(2^28 / 1000); exact for every dividend up to SAT_MAX.
	localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

	typedef enum logic [IDX_W-1:0] {
		REG_LUMA_GAIN    = 3'd0,
		REG_RED_FROM_V   = 3'd1,
		REG_GREEN_FROM_U = 3'd2,
		REG_GREEN_FROM_V = 3'd3,
		REG_BLUE_FROM_U  = 3'd4
	} y2r_reg_t;

	typedef struct packed {
		logic [COEF_W-1:0] luma_gain;
		logic [COEF_W-1:0] red_from_v;
		logic [COEF_W-1:0] green_from_u;
		logic [COEF_W-1:0] green_from_v;
		logic [COEF_W-1:0] blue_from_u;
	} y2r_coef_t;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} y2r_pipe_en_t;

	// Clip a channel sum to 0..SAT_MAX; negative sums divide to zero or below.
	function automatic logic [SAT_W-1:0] sat_acc(input logic signed [ACC_W-1:0] acc);
		logic [SAT_W-1:0] res;
		if (acc[ACC_W-1]) begin
			res = '0;
		end else if (acc >= SAT_LIMIT) begin
			res = SAT_MAX;
		end else begin
			res = acc[SAT_W-1:0];
		end
		return res;
	endfunction

	// Divide by 1000 through a reciprocal multiply.
	function automatic logic [BYTE_W-1:0] div1000(input logic [SAT_W-1:0] x);
		logic [SAT_W+RECIP_W-1:0] p;
		p = (SAT_W+RECIP_W)'(x) * (SAT_W+RECIP_W)'(RECIP_1000);
		return p[DIV_SHIFT+BYTE_W-1:DIV_SHIFT];
	endfunction

endpackage

/* rtl/y2r_cfg.sv */
// Coefficient register bank with index decode.
module y2r_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [y2r_pkg::IDX_W-1:0]      cfg_index,
	input  logic [y2r_pkg::COEF_W-1:0]     cfg_data,
	output y2r_pkg::y2r_coef_t             coef
);
	import y2r_pkg::*;

	y2r_coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.luma_gain    <= LUMA_GAIN_RST;
			coef_q.red_from_v   <= RED_FROM_V_RST;
			coef_q.green_from_u <= GREEN_FROM_U_RST;
			coef_q.green_from_v <= GREEN_FROM_V_RST;
			coef_q.blue_from_u  <= BLUE_FROM_U_RST;
		end else if (cfg_wr_en) begin
			unique case (y2r_reg_t'(cfg_index))
				REG_LUMA_GAIN:    coef_q.luma_gain    <= cfg_data;
				REG_RED_FROM_V:   coef_q.red_from_v   <= cfg_data;
				REG_GREEN_FROM_U: coef_q.green_from_u <= cfg_data;
				REG_GREEN_FROM_V: coef_q.green_from_v <= cfg_data;
				REG_BLUE_FROM_U:  coef_q.blue_from_u  <= cfg_data;
				default: ; // drop writes past the last register
			endcase
		end
	end

	assign coef = coef_q;

endmodule

/* rtl/y2r_pipe_ctrl.sv */
// Valid tracking and per-stage load enables for the four-stage pipeline.
module y2r_pipe_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  logic                      out_stall,
	output y2r_pkg::y2r_pipe_en_t     en
);
	import y2r_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	y2r_pipe_en_t en_c;

	// A stage loads when it is empty or its content moves on.
	always_comb begin
		en_c.ld_s4 = !v_s4 || !out_stall;
		en_c.ld_s3 = !v_s3 || en_c.ld_s4;
		en_c.ld_s2 = !v_s2 || en_c.ld_s3;
		en_c.ld_s1 = !v_s1 || en_c.ld_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_c.ld_s1) v_s1 <= in_valid;
			if (en_c.ld_s2) v_s2 <= v_s1;
			if (en_c.ld_s3) v_s3 <= v_s2;
			if (en_c.ld_s4) v_s4 <= v_s3;
		end
	end

	assign in_stall  = !en_c.ld_s1;
	assign out_valid = v_s4;
	assign en        = en_c;

endmodule

/* rtl/yuyv422_to_rgb24_pair.sv */
// Top level of the YUYV 4:2:2 macropixel to RGB24 pixel pair converter.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one YUYV macropixel per request:
//   two luma bytes and the shared U (chroma_blue) and V (chroma_red) bytes.
//   Output channel (out_valid / out_stall) carries two RGB24 pixels per request.
//   Each channel is (gain * component) summed per color, divided by 1000 with
//   truncation, and clamped to 0..255.
//   A request accepted at one clock edge moves through the stage 1, 2 and 3
//   registers into the output register, unless a stall holds it on the way.
//   Throughput is one request per cycle: each of the four register stages
//   (input capture, coefficient products, channel sums with saturation,
//   reciprocal divide) reloads at every edge unless the stage after it holds.
//   When the receiver stalls, the output holds; earlier stages keep filling
//   bubbles, so in_stall rises only once every stage holds a request.
//   Reset clears all stage valids and loads the default coefficients, which the
//   user must write through cfg_wr_en / cfg_index / cfg_data only while the
//   block is idle, which the block does not enforce. Unused indexes are ignored.
module yuyv422_to_rgb24_pair (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [y2r_pkg::IDX_W-1:0]    cfg_index,
	input  logic [y2r_pkg::COEF_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [y2r_pkg::BYTE_W-1:0]   luma_first,
	input  logic [y2r_pkg::BYTE_W-1:0]   chroma_blue,
	input  logic [y2r_pkg::BYTE_W-1:0]   luma_second,
	input  logic [y2r_pkg::BYTE_W-1:0]   chroma_red,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [y2r_pkg::BYTE_W-1:0]   red_first,
	output logic [y2r_pkg::BYTE_W-1:0]   green_first,
	output logic [y2r_pkg::BYTE_W-1:0]   blue_first,
	output logic [y2r_pkg::BYTE_W-1:0]   red_second,
	output logic [y2r_pkg::BYTE_W-1:0]   green_second,
	output logic [y2r_pkg::BYTE_W-1:0]   blue_second
);
	import y2r_pkg::*;

	y2r_coef_t    coef;
	y2r_pipe_en_t en;

	y2r_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	y2r_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.en        (en)
	);

	// Stage 1: capture the macropixel.
	logic [BYTE_W-1:0] y0_s1, y1_s1, u_s1, v_s1;

	always_ff @(posedge clk) begin
		if (en.ld_s1) begin
			y0_s1 <= luma_first;
			y1_s1 <= luma_second;
			u_s1  <= chroma_blue;
			v_s1  <= chroma_red;
		end
	end

	// Stage 2: remove offsets and form all six products.
	// Chroma products are shared by both pixels.
	logic signed [8:0] d0, d1, cu, cv;
	logic signed [PROD_W-1:0] y0_prod, y1_prod, rv_prod, gu_prod, gv_prod, bu_prod;
	logic signed [PROD_W-1:0] y0_prod_s2, y1_prod_s2;
	logic signed [PROD_W-1:0] rv_prod_s2, gu_prod_s2, gv_prod_s2, bu_prod_s2;

	always_comb begin
		d0 = $signed({1'b0, y0_s1}) - LUMA_OFFSET;
		d1 = $signed({1'b0, y1_s1}) - LUMA_OFFSET;
		cu = $signed({1'b0, u_s1}) - CHROMA_OFFSET;
		cv = $signed({1'b0, v_s1}) - CHROMA_OFFSET;
		y0_prod = $signed({1'b0, coef.luma_gain})    * d0;
		y1_prod = $signed({1'b0, coef.luma_gain})    * d1;
		rv_prod = $signed({1'b0, coef.red_from_v})   * cv;
		gu_prod = $signed({1'b0, coef.green_from_u}) * cu;
		gv_prod = $signed({1'b0, coef.green_from_v}) * cv;
		bu_prod = $signed({1'b0, coef.blue_from_u})  * cu;
	end

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			y0_prod_s2 <= y0_prod;
			y1_prod_s2 <= y1_prod;
			rv_prod_s2 <= rv_prod;
			gu_prod_s2 <= gu_prod;
			gv_prod_s2 <= gv_prod;
			bu_prod_s2 <= bu_prod;
		end
	end

	// Stage 3: sum each channel and saturate to the range that divides to 0..255.
	logic signed [ACC_W-1:0] r0_acc, g0_acc, b0_acc, r1_acc, g1_acc, b1_acc;
	logic [SAT_W-1:0] r0_s3, g0_s3, b0_s3, r1_s3, g1_s3, b1_s3;

	always_comb begin
		r0_acc = ACC_W'(y0_prod_s2) + ACC_W'(rv_prod_s2);
		g0_acc = ACC_W'(y0_prod_s2) + ACC_W'(gu_prod_s2) - ACC_W'(gv_prod_s2);
		b0_acc = ACC_W'(y0_prod_s2) + ACC_W'(bu_prod_s2);
		r1_acc = ACC_W'(y1_prod_s2) + ACC_W'(rv_prod_s2);
		g1_acc = ACC_W'(y1_prod_s2) + ACC_W'(gu_prod_s2) - ACC_W'(gv_prod_s2);
		b1_acc = ACC_W'(y1_prod_s2) + ACC_W'(bu_prod_s2);
	end

	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			r0_s3 <= sat_acc(r0_acc);
			g0_s3 <= sat_acc(g0_acc);
			b0_s3 <= sat_acc(b0_acc);
			r1_s3 <= sat_acc(r1_acc);
			g1_s3 <= sat_acc(g1_acc);
			b1_s3 <= sat_acc(b1_acc);
		end
	end

	// Stage 4: divide by 1000 into the output register; hold while stalled.
	logic [BYTE_W-1:0] r0_s4, g0_s4, b0_s4, r1_s4, g1_s4, b1_s4;

	always_ff @(posedge clk) begin
		if (en.ld_s4) begin
			r0_s4 <= div1000(r0_s3);
			g0_s4 <= div1000(g0_s3);
			b0_s4 <= div1000(b0_s3);
			r1_s4 <= div1000(r1_s3);
			g1_s4 <= div1000(g1_s3);
			b1_s4 <= div1000(b1_s3);
		end
	end

	assign red_first    = r0_s4;
	assign green_first  = g0_s4;
	assign blue_first   = b0_s4;
	assign red_second   = r1_s4;
	assign green_second = g1_s4;
	assign blue_second  = b1_s4;

endmodule

/* dv/y2r_pair_checker.sv */
`timescale 1ns / 1ps
// Checker for the YUYV to RGB pair converter: predicts each pixel pair and compares it.
module y2r_pair_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [y2r_pkg::IDX_W-1:0]  cfg_index,
	input  logic [y2r_pkg::COEF_W-1:0] cfg_data,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [y2r_pkg::BYTE_W-1:0] luma_first,
	input  logic [y2r_pkg::BYTE_W-1:0] chroma_blue,
	input  logic [y2r_pkg::BYTE_W-1:0] luma_second,
	input  logic [y2r_pkg::BYTE_W-1:0] chroma_red,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [y2r_pkg::BYTE_W-1:0] red_first,
	input  logic [y2r_pkg::BYTE_W-1:0] green_first,
	input  logic [y2r_pkg::BYTE_W-1:0] blue_first,
	input  logic [y2r_pkg::BYTE_W-1:0] red_second,
	input  logic [y2r_pkg::BYTE_W-1:0] green_second,
	input  logic [y2r_pkg::BYTE_W-1:0] blue_second,
	output int                         fail_count,
	output int                         pending
);
	import y2r_pkg::*;

	localparam int DIVISOR   = 1000;
	localparam int CHAN_MAX  = 255;

	typedef struct packed {
		logic [BYTE_W-1:0] red_first;
		logic [BYTE_W-1:0] green_first;
		logic [BYTE_W-1:0] blue_first;
		logic [BYTE_W-1:0] red_second;
		logic [BYTE_W-1:0] green_second;
		logic [BYTE_W-1:0] blue_second;
	} rgb_pair_t;

	y2r_coef_t coef;
	rgb_pair_t expected_pairs [$];
	rgb_pair_t want;
	int errors = 0;

	assign fail_count = errors;

	// Divide by 1000 toward zero, then clamp to a byte.
	function automatic logic [BYTE_W-1:0] to_channel(input int acc);
		int q;
		q = acc / DIVISOR;
		if (q < 0) return '0;
		if (q > CHAN_MAX) return BYTE_W'(CHAN_MAX);
		return q[BYTE_W-1:0];
	endfunction

	function automatic logic [3*BYTE_W-1:0] yuv_to_rgb(input logic [BYTE_W-1:0] luma,
			input int cu, input int cv);
		int base;
		base = int'(coef.luma_gain) * (int'(luma) - int'(LUMA_OFFSET));
		return {to_channel(base + int'(coef.red_from_v) * cv),
			to_channel(base + int'(coef.green_from_u) * cu - int'(coef.green_from_v) * cv),
			to_channel(base + int'(coef.blue_from_u) * cu)};
	endfunction

	function automatic rgb_pair_t convert_pair(input logic [BYTE_W-1:0] y0,
			input logic [BYTE_W-1:0] u, input logic [BYTE_W-1:0] y1,
			input logic [BYTE_W-1:0] v);
		int cu;
		int cv;
		rgb_pair_t px;
		cu = int'(u) - int'(CHROMA_OFFSET);
		cv = int'(v) - int'(CHROMA_OFFSET);
		{px.red_first, px.green_first, px.blue_first} = yuv_to_rgb(y0, cu, cv);
		{px.red_second, px.green_second, px.blue_second} = yuv_to_rgb(y1, cu, cv);
		return px;
	endfunction

	// Print one line per error and count it.
	task automatic report_error(input string msg);
		$display("@%0t %s", $time, msg);
		errors++;
	endtask

	task automatic check_byte(input string name, input logic [BYTE_W-1:0] got,
			input logic [BYTE_W-1:0] exp_val);
		if (got !== exp_val)
			report_error($sformatf("%s got %0d want %0d", name, got, exp_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef <= {LUMA_GAIN_RST, RED_FROM_V_RST, GREEN_FROM_U_RST,
				GREEN_FROM_V_RST, BLUE_FROM_U_RST};
			expected_pairs.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pairs.size() == 0) begin
					report_error("pixel pair with no request waiting");
				end else begin
					want = expected_pairs.pop_front();
					check_byte("red_first", red_first, want.red_first);
					check_byte("green_first", green_first, want.green_first);
					check_byte("blue_first", blue_first, want.blue_first);
					check_byte("red_second", red_second, want.red_second);
					check_byte("green_second", green_second, want.green_second);
					check_byte("blue_second", blue_second, want.blue_second);
				end
			end
			if (in_valid && !in_stall)
				expected_pairs.push_back(convert_pair(luma_first, chroma_blue,
					luma_second, chroma_red));
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_LUMA_GAIN:    coef.luma_gain <= cfg_data;
					REG_RED_FROM_V:   coef.red_from_v <= cfg_data;
					REG_GREEN_FROM_U: coef.green_from_u <= cfg_data;
					REG_GREEN_FROM_V: coef.green_from_v <= cfg_data;
					REG_BLUE_FROM_U:  coef.blue_from_u <= cfg_data;
					default: ;
				endcase
			end
			pending <= expected_pairs.size();
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the YUYV to RGB pair converter: stimulus, watchdog and verdict.
module tb_top;
	import y2r_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 5;
	localparam int IDLE_PCT       = 23;
	localparam int RAND_PER_PHASE = 64;
	// Pipeline is four stages deep; this is the settling wait after it drains.
	localparam int SETTLE_CYCLES  = 8;
	localparam int QUIET_LIMIT    = 2000;
	localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};
	localparam logic [IDX_W-1:0] REG_UNUSED_FIRST = IDX_W'(REG_BLUE_FROM_U + 1);
	localparam logic [IDX_W-1:0] REG_UNUSED_LAST  = {IDX_W{1'b1}};

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [IDX_W-1:0]  cfg_index   = '0;
	logic [COEF_W-1:0] cfg_data    = '0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] luma_first  = '0;
	logic [BYTE_W-1:0] chroma_blue = '0;
	logic [BYTE_W-1:0] luma_second = '0;
	logic [BYTE_W-1:0] chroma_red  = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [BYTE_W-1:0] red_first;
	logic [BYTE_W-1:0] green_first;
	logic [BYTE_W-1:0] blue_first;
	logic [BYTE_W-1:0] red_second;
	logic [BYTE_W-1:0] green_second;
	logic [BYTE_W-1:0] blue_second;

	int   fail_count;
	int   pending;
	int   quiet_cycles = 0;
	// High while neither side may idle.
	logic steady = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	yuyv422_to_rgb24_pair dut (.*);

	y2r_pair_checker checker_i (.*);

	// Stall the output at random unless a steady stretch is running.
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99, 0) < IDLE_PCT);
	end

	// End the run if nothing moves on any port for too long.
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Mostly uniform bytes, with the corners and the offsets mixed in.
	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(9, 0))
			0: return '0;
			1: return '1;
			2: return BYTE_W'(LUMA_OFFSET);
			3: return BYTE_W'(CHROMA_OFFSET);
			default: return BYTE_W'($urandom_range(255, 0));
		endcase
	endfunction

	// Random coefficient across the full register range.
	function automatic logic [COEF_W-1:0] pick_coef();
		return COEF_W'($urandom_range(COEF_MAX, 0));
	endfunction

	// Offer one macropixel request and hold it until the block takes it.
	// Idle gaps come first, so valid never waits on stall.
	task automatic send_macropixel(input logic [BYTE_W-1:0] y0, input logic [BYTE_W-1:0] u,
			input logic [BYTE_W-1:0] y1, input logic [BYTE_W-1:0] v);
		while (!steady && ($urandom_range(99, 0) < IDLE_PCT)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		luma_first  <= y0;
		chroma_blue <= u;
		luma_second <= y1;
		chroma_red  <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
	endtask

	// Drop valid, wait for every pixel pair to come back, then let the pipe settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Raise the write enable with one write and wait for the clock edge; the caller lowers it after the last write.
	task automatic put_reg(input logic [IDX_W-1:0] index, input logic [COEF_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic load_coefs(input logic [COEF_W-1:0] gain_y, input logic [COEF_W-1:0] r_v,
			input logic [COEF_W-1:0] g_u, input logic [COEF_W-1:0] g_v,
			input logic [COEF_W-1:0] b_u);
		put_reg(REG_LUMA_GAIN, gain_y);
		put_reg(REG_RED_FROM_V, r_v);
		put_reg(REG_GREEN_FROM_U, g_u);
		put_reg(REG_GREEN_FROM_V, g_v);
		put_reg(REG_BLUE_FROM_U, b_u);
		// Poke an index past the register list; the block must drop it.
		put_reg(IDX_W'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)), pick_coef());
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset coefficients: corners, black and white, pure colors, green sign.
		send_macropixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_macropixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_macropixel(8'd16, 8'd128, 8'd16, 8'd128);
		send_macropixel(8'd235, 8'd128, 8'd235, 8'd128);
		send_macropixel(8'd255, 8'd128, 8'd0, 8'd128);
		send_macropixel(8'd128, 8'd0, 8'd128, 8'd0);
		send_macropixel(8'd128, 8'd255, 8'd128, 8'd255);
		// Low U with high V pulls green down; the reverse pushes it up.
		send_macropixel(8'd128, 8'd0, 8'd128, 8'd255);
		send_macropixel(8'd128, 8'd255, 8'd128, 8'd0);
		send_macropixel(8'd81, 8'd90, 8'd81, 8'd240);
		send_macropixel(8'd41, 8'd240, 8'd110, 8'd110);
		// Luma just either side of its offset: small sums truncate toward zero.
		send_macropixel(8'd15, 8'd128, 8'd17, 8'd128);
		send_macropixel(8'd16, 8'd127, 8'd16, 8'd129);
		send_macropixel(8'd0, 8'd128, 8'd255, 8'd128);
		send_random(RAND_PER_PHASE);

		// Every gain at full scale: sums saturate both ways.
		wait_idle();
		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		send_macropixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_macropixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_macropixel(8'd16, 8'd255, 8'd16, 8'd0);
		send_macropixel(8'd16, 8'd0, 8'd16, 8'd255);
		send_random(RAND_PER_PHASE);

		// Every gain zero: all channels collapse to zero.
		wait_idle();
		load_coefs('0, '0, '0, '0, '0);
		send_random(RAND_PER_PHASE);

		// Full luma gain, random chroma gains, and no idling on either side.
		wait_idle();
		load_coefs(COEF_MAX, pick_coef(), pick_coef(), pick_coef(), pick_coef());
		steady <= 1'b1;
		send_random(RAND_PER_PHASE);
		steady <= 1'b0;

		wait_idle();
		load_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
		send_random(RAND_PER_PHASE);

		// Write the reset values back explicitly.
		wait_idle();
		load_coefs(LUMA_GAIN_RST, RED_FROM_V_RST, GREEN_FROM_U_RST, GREEN_FROM_V_RST,
			BLUE_FROM_U_RST);
		send_random(RAND_PER_PHASE);

		wait_idle();
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
